[hw/rtl/sidc_pkg.sv]
// Shared types and constants for the session ID cache.
`timescale 1ns / 1ps
package sidc_pkg;
  localparam logic [1:0] FUNC_FIND   = 2'd0;
  localparam logic [1:0] FUNC_SAVE   = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;

  localparam logic CFG_LIFETIME = 1'b0;
  localparam logic CFG_ENTRIES  = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  id_length;
    logic [63:0] id_word;
    logic        word_last;
    logic [31:0] now;
    logic [15:0] session_handle;
  } sidc_in_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  entry_index;
    logic [15:0] found_handle;
    logic        written;
    logic [1:0]  status;
  } sidc_out_t;
endpackage

[hw/rtl/session_id_cache_unit.sv]
// Top level of the session ID cache: word gathering, scan sequencer and entry store.
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low. Words without
// word_last are absorbed and leave busy low. A word with word_last
// starts the operation: find first sweeps entries 0..n-1 for expiry,
// one entry per cycle, then the operation scans the same entries through
// a single shared compare unit, stopping early when find or save matches,
// and a final done state writes the table on a save and forms the result.
// Here n is the entries in use, clamped to 1..ENTRIES. An ignored command
// goes straight to the done state. The result strobes out_valid for one
// cycle, the first cycle with busy low, and must be taken then: the
// receiver cannot stall. The table is cleared at once by reset through
// per-entry valid flags.
module session_id_cache_unit
  import sidc_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int ID_WORDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  sidc_in_t    in_data,
  output logic        out_valid,
  output sidc_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IDB = ID_WORDS * 64;
  localparam logic [6:0] MAXLEN = 7'(ID_WORDS * 8);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [31:0] lifetime_r;
  logic [4:0]  inuse_r;
  logic [WW-1:0] wc_r;
  logic [63:0] inc_r [ID_WORDS];
  logic [IDB-1:0] inc_masked;
  logic [1:0]  func_r;
  logic [5:0]  len_r;
  logic [31:0] now_r;
  logic [15:0] hdl_r;
  logic [CW-1:0] ptr_r, ncount;
  logic [EW-1:0] idx;

  logic [ENTRIES-1:0] vld_r;
  logic [5:0]     e_len_r [ENTRIES];
  logic [IDB-1:0] e_id_r  [ENTRIES];
  logic [31:0]    e_time_r[ENTRIES];
  logic [15:0]    e_hdl_r [ENTRIES];

  logic have_free_r, have_old_r, found_r;
  logic [EW-1:0] free_r, old_r, hit_r;
  logic [IDB-1:0] mask;
  logic match, expired, older;
  logic [31:0] age;

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign idx = ptr_r[EW-1:0];

  // Clamp the entry count to 1..ENTRIES.
  always_comb begin
    if (inuse_r == 5'd0) ncount = CW'(1);
    else if (32'(inuse_r) > ENTRIES) ncount = CW'(ENTRIES);
    else ncount = CW'(inuse_r);
  end

  // Byte mask over the whole ID, first byte at the top.
  always_comb begin
    for (int b = 0; b < ID_WORDS * 8; b++) begin
      mask[IDB - 1 - b*8 -: 8] = (7'(b) < {1'b0, len_r}) ? 8'hff : 8'h00;
    end
    for (int w = 0; w < ID_WORDS; w++) begin
      inc_masked[IDB - 1 - w*64 -: 64] = inc_r[w];
    end
    inc_masked = inc_masked & mask;
  end

  // Shared per-entry compare unit.
  assign match = vld_r[idx] && (e_len_r[idx] == len_r) && ((e_id_r[idx] & mask) == inc_masked);
  assign age = now_r - e_time_r[idx];
  assign expired = vld_r[idx] && (age >= lifetime_r);
  assign older = ((e_time_r[idx] - e_time_r[old_r]) & 32'h8000_0000) != 32'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && in_data.word_last) begin
          if (in_data.id_length == 6'd0 || in_data.func == FUNC_UNUSED) state_nxt = S_DONE;
          else if (in_data.func == FUNC_FIND) state_nxt = S_EXP;
          else state_nxt = S_SCAN;
        end
      end
      S_EXP:  if (ptr_r == ncount - CW'(1)) state_nxt = S_SCAN;
      S_SCAN: begin
        if (ptr_r == ncount - CW'(1)) state_nxt = S_DONE;
        else if (match && func_r != FUNC_REMOVE) state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      lifetime_r <= 32'd3600000;
      inuse_r <= 5'd16;
      wc_r <= '0;
      vld_r <= '0;
      ptr_r <= '0;
      for (int w = 0; w < ID_WORDS; w++) inc_r[w] <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_DONE);
      // Configuration beat
      if (cfg_valid) begin
        if (cfg_index == CFG_LIFETIME) lifetime_r <= cfg_data;
        else inuse_r <= cfg_data[4:0];
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            inc_r[wc_r] <= in_data.id_word;
            if (!in_data.word_last) begin
              if (32'(wc_r) < ID_WORDS - 1) wc_r <= wc_r + WW'(1);
            end else begin
              func_r <= in_data.func;
              len_r <= ({1'b0, in_data.id_length} > MAXLEN) ? 6'(MAXLEN) : in_data.id_length;
              now_r <= in_data.now;
              hdl_r <= in_data.session_handle;
              ptr_r <= '0;
              have_free_r <= 1'b0;
              have_old_r <= 1'b0;
              found_r <= 1'b0;
              free_r <= '0;
              old_r <= '0;
              hit_r <= '0;
              out_data.hit <= 1'b0;
              out_data.entry_index <= '0;
              out_data.found_handle <= '0;
              out_data.written <= 1'b0;
              out_data.status <=
                (in_data.id_length == 6'd0 || in_data.func == FUNC_UNUSED) ?
                ST_IGNORED : ST_DONE;
            end
          end
        end
        // Drop expired entries
        S_EXP: begin
          if (expired) vld_r[idx] <= 1'b0;
          ptr_r <= (ptr_r == ncount - CW'(1)) ? '0 : ptr_r + CW'(1);
        end
        S_SCAN: begin
          ptr_r <= ptr_r + CW'(1);
          if (match) begin
            if (func_r == FUNC_REMOVE) vld_r[idx] <= 1'b0;
            else begin
              found_r <= 1'b1;
              hit_r <= idx;
            end
          end else if (!vld_r[idx]) begin
            if (!have_free_r) begin
              have_free_r <= 1'b1;
              free_r <= idx;
            end
          end else if (!have_old_r || older) begin
            have_old_r <= 1'b1;
            old_r <= idx;
          end
        end
        S_DONE: begin
          wc_r <= '0;
          for (int w = 0; w < ID_WORDS; w++) inc_r[w] <= '0;
          if (out_data.status == ST_DONE) begin
            if (func_r == FUNC_FIND && found_r) begin
              out_data.hit <= 1'b1;
              out_data.entry_index <= 4'(hit_r);
              out_data.found_handle <= e_hdl_r[hit_r];
            end else if (func_r == FUNC_SAVE) begin
              if (found_r) begin
                out_data.status <= ST_PRESENT;
                out_data.entry_index <= 4'(hit_r);
              end else begin
                // Write to first free, else oldest
                vld_r[have_free_r ? free_r : old_r] <= 1'b1;
                out_data.written <= 1'b1;
                out_data.entry_index <= 4'(have_free_r ? free_r : old_r);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Entry payload store
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_data.status == ST_DONE && func_r == FUNC_SAVE && !found_r) begin
      e_len_r [have_free_r ? free_r : old_r] <= len_r;
      e_id_r  [have_free_r ? free_r : old_r] <= inc_masked;
      e_time_r[have_free_r ? free_r : old_r] <= now_r;
      e_hdl_r [have_free_r ? free_r : old_r] <= hdl_r;
    end
  end
endmodule

[hw/rtl/sidc_checker.sv]
// Port-level checks for the session ID cache, bound to the top level.
`timescale 1ns / 1ps
module sidc_checker
  import sidc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input sidc_out_t out_data
);
  // Result only for a busy operation.
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without operation");
  // Hit only when status done.
  a_hit_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.status == ST_DONE) else $error("hit status");
  // Hit and written exclusive.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.written)) else $error("hit and written");
  // Single-cycle strobe.
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one beat");
  // Stay idle without a command.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> !busy) else $error("busy without command");
endmodule

bind session_id_cache_unit sidc_checker u_sidc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);
